// ----- rtl/tup_pkg.sv -----
package tup_pkg;

  localparam int TUP_VALUE_WIDTH = 64;
  localparam int TUP_MAX_CHARS   = 4096;
  localparam int TUP_QUEUE_DEPTH = 2;

  localparam int TUP_RADIX_W = 6;
  localparam int TUP_CH_W    = 8;
  localparam int TUP_END_W   = 12;

  localparam logic [TUP_END_W-1:0]   TUP_END_MAX     = '1;
  localparam logic [TUP_RADIX_W-1:0] TUP_RADIX_RESET = 6'd10;
  localparam logic [TUP_RADIX_W-1:0] TUP_RADIX_AUTO  = 6'd0;
  localparam logic [TUP_RADIX_W-1:0] TUP_RADIX_BAD   = 6'd1;
  localparam logic [TUP_RADIX_W-1:0] TUP_RADIX_MAX   = 6'd36;
  localparam logic [TUP_RADIX_W-1:0] TUP_BASE_OCT    = 6'd8;
  localparam logic [TUP_RADIX_W-1:0] TUP_BASE_DEC    = 6'd10;
  localparam logic [TUP_RADIX_W-1:0] TUP_BASE_HEX    = 6'd16;
  localparam logic [TUP_RADIX_W-1:0] TUP_DIGIT_NONE  = 6'd63;

  // character codes
  localparam logic [TUP_CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [TUP_CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [TUP_CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [TUP_CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [TUP_CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [TUP_CH_W-1:0] CH_0     = 8'h30;
  localparam logic [TUP_CH_W-1:0] CH_9     = 8'h39;
  localparam logic [TUP_CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [TUP_CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [TUP_CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [TUP_CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [TUP_CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [TUP_CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [TUP_CH_W-1:0] CH_ALPHA_OFS = 8'h37;  // 'A' - 10
  localparam logic [TUP_CH_W-1:0] CH_LOWER_OFS = 8'h57;  // 'a' - 10

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_SOME,
    DS_OVER
  } digit_status_t;

  // one classified byte
  typedef struct packed {
    logic                   start;
    logic [TUP_RADIX_W-1:0] radix;
    logic [TUP_RADIX_W-1:0] digit;
    logic                   is_space;
    logic                   is_minus;
    logic                   is_plus;
    logic                   is_x;
  } token_t;

endpackage

// ----- rtl/tup_front.sv -----
module tup_front import tup_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TUP_CH_W-1:0]    in_ch,
  input  logic                   in_start_req,
  input  logic                   cfg_wr_en,
  input  logic [TUP_RADIX_W-1:0] cfg_wr_data,
  input  logic                   q_full,
  output logic                   q_push,
  output token_t                 q_tok
);

  logic [TUP_RADIX_W-1:0] radix_r;
  logic [TUP_CH_W-1:0]    digit_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= TUP_RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (in_ch inside {[CH_0:CH_9]}) begin
      digit_wide = in_ch - CH_0;
    end else if (in_ch inside {[CH_UA:CH_UZ]}) begin
      digit_wide = in_ch - CH_ALPHA_OFS;
    end else if (in_ch inside {[CH_LA:CH_LZ]}) begin
      digit_wide = in_ch - CH_LOWER_OFS;
    end else begin
      digit_wide = TUP_CH_W'(TUP_DIGIT_NONE);
    end
  end

  always_comb begin
    q_tok.start    = in_start_req;
    q_tok.radix    = radix_r;
    q_tok.digit    = digit_wide[TUP_RADIX_W-1:0];
    q_tok.is_space = (in_ch == CH_SPACE) || (in_ch inside {[CH_TAB:CH_CR]});
    q_tok.is_minus = (in_ch == CH_MINUS);
    q_tok.is_plus  = (in_ch == CH_PLUS);
    q_tok.is_x     = (in_ch == CH_LX) || (in_ch == CH_UX);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- rtl/tup_fifo.sv -----
module tup_fifo import tup_pkg::*; #(
  parameter int DEPTH = TUP_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t wr_tok,
  output logic   full,
  input  logic   pop,
  output token_t rd_tok,
  output logic   not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign rd_tok    = slots[rd_ptr_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);

  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  ap_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  ap_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/tup_back.sv -----
module tup_back import tup_pkg::*; #(
  parameter int VALUE_WIDTH = TUP_VALUE_WIDTH,
  parameter int MAX_CHARS   = TUP_MAX_CHARS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tok_valid,
  input  token_t                 tok,
  output logic                   tok_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [TUP_END_W-1:0]   out_end_offset,
  output logic                   out_overflow,
  output logic                   out_any_digits
);

  localparam int IW = $clog2(MAX_CHARS);
  localparam int XW = (IW > TUP_END_W) ? IW : TUP_END_W;
  localparam int PW = VALUE_WIDTH + TUP_RADIX_W + 1;

  phase_t                 ph_r, ph_nxt, ph_c;
  digit_status_t          ds_r, ds_nxt, ds_c;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt, acc_c;
  logic [TUP_RADIX_W-1:0] base_r, base_nxt, base_c;
  logic                   minus_r, minus_nxt, minus_c;
  logic [IW-1:0]          idx_r, idx_nxt, idx_c;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [TUP_END_W-1:0]   out_end_r;
  logic                   out_ovf_r, out_any_r;

  logic                   pop, bad_radix;
  logic                   to_signed, to_digits, do_acc;
  logic [PW-1:0]          acc_prod, acc_sum;
  logic                   acc_ovf;

  logic                   em;
  logic [VALUE_WIDTH-1:0] em_value;
  logic [TUP_END_W-1:0]   em_end;
  logic                   em_ovf, em_any;

  function automatic logic [TUP_END_W-1:0] sat_end(input logic [IW-1:0] i);
    logic [XW-1:0] e;
    e = XW'(i);
    return (e > XW'(TUP_END_MAX)) ? TUP_END_MAX : e[TUP_END_W-1:0];
  endfunction

  // state as seen by this byte, after a start clears it
  always_comb begin
    ph_c    = tok.start ? PH_LEAD : ph_r;
    ds_c    = tok.start ? DS_NONE : ds_r;
    acc_c   = tok.start ? '0 : acc_r;
    base_c  = tok.start ? tok.radix : base_r;
    minus_c = tok.start ? 1'b0 : minus_r;
    idx_c   = tok.start ? '0 : idx_r;
  end

  assign bad_radix = tok.start && ((tok.radix == TUP_RADIX_BAD) || (tok.radix > TUP_RADIX_MAX));

  // base is 6 bits wide: a VALUE_WIDTH by 6 multiply, then the digit add.
  // acc_c is zero whenever base_c differs from base_r
  assign acc_prod = PW'(acc_c) * PW'(base_r);
  assign acc_sum  = acc_prod + PW'(tok.digit);
  assign acc_ovf  = |acc_sum[PW-1:VALUE_WIDTH];

  always_comb begin
    ph_nxt    = ph_c;
    ds_nxt    = ds_c;
    acc_nxt   = acc_c;
    base_nxt  = base_c;
    minus_nxt = minus_c;
    idx_nxt   = idx_c;
    to_signed = 1'b0;
    to_digits = 1'b0;
    do_acc    = 1'b0;
    em        = 1'b0;
    em_value  = '0;
    em_end    = '0;
    em_ovf    = 1'b0;
    em_any    = 1'b0;

    case (ph_c)
      PH_LEAD: begin
        if (tok.is_space) begin
        end else if (tok.is_minus) begin
          minus_nxt = 1'b1;
          ph_nxt    = PH_SIGNED;
        end else if (tok.is_plus) begin
          ph_nxt = PH_SIGNED;
        end else begin
          to_signed = 1'b1;
        end
      end
      PH_SIGNED: begin
        to_signed = 1'b1;
      end
      PH_ZERO: begin
        if (tok.is_x) begin
          base_nxt = TUP_BASE_HEX;
          ph_nxt   = PH_XSEEN;
        end else begin
          if (base_c == TUP_RADIX_AUTO) begin
            base_nxt = TUP_BASE_OCT;
          end
          ph_nxt    = PH_DIGITS;
          to_digits = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (tok.digit < TUP_BASE_HEX) begin
          do_acc = 1'b1;
        end else begin
          // "0x" with no hex digit: the zero is the number
          em     = 1'b1;
          em_end = sat_end(idx_c - IW'(1));
          em_any = 1'b1;
          ph_nxt = PH_IDLE;
        end
      end
      PH_DIGITS: begin
        to_digits = 1'b1;
      end
      default: begin
      end
    endcase

    if (to_signed) begin
      if ((tok.digit == '0) && ((base_c == TUP_RADIX_AUTO) || (base_c == TUP_BASE_HEX))) begin
        acc_nxt = '0;
        ds_nxt  = DS_SOME;
        ph_nxt  = PH_ZERO;
      end else begin
        if (base_c == TUP_RADIX_AUTO) begin
          base_nxt = TUP_BASE_DEC;
        end
        to_digits = 1'b1;
      end
    end

    if (to_digits) begin
      if (tok.digit < base_nxt) begin
        do_acc = 1'b1;
      end else begin
        em     = 1'b1;
        ph_nxt = PH_IDLE;
        case (ds_c)
          DS_OVER: begin
            em_value = '1;
            em_end   = sat_end(idx_c);
            em_ovf   = 1'b1;
            em_any   = 1'b1;
          end
          DS_SOME: begin
            em_value = minus_c ? (VALUE_WIDTH'(0) - acc_c) : acc_c;
            em_end   = sat_end(idx_c);
            em_any   = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (do_acc && (ds_c != DS_OVER)) begin
      if (acc_ovf) begin
        ds_nxt  = DS_OVER;
        acc_nxt = '1;
      end else begin
        ds_nxt  = DS_SOME;
        acc_nxt = acc_sum[VALUE_WIDTH-1:0];
      end
    end
    if (do_acc) begin
      ph_nxt = PH_DIGITS;
    end

    if ((ph_c != PH_IDLE) && (idx_c < IW'(MAX_CHARS - 1))) begin
      idx_nxt = idx_c + IW'(1);
    end

    // bad radix ends the string on the start byte itself
    if (bad_radix) begin
      em       = 1'b1;
      em_value = '0;
      em_end   = '0;
      em_ovf   = 1'b0;
      em_any   = 1'b0;
      ph_nxt   = PH_IDLE;
      acc_nxt  = '0;
      ds_nxt   = DS_NONE;
      base_nxt = tok.radix;
      idx_nxt  = '0;
    end
  end

  assign pop       = tok_valid && (!out_valid_r || out_ready);
  assign tok_ready = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      ds_r    <= DS_NONE;
      acc_r   <= '0;
      base_r  <= '0;
      minus_r <= 1'b0;
      idx_r   <= '0;
    end else if (pop) begin
      ph_r    <= ph_nxt;
      ds_r    <= ds_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      minus_r <= minus_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && em) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && em) begin
      out_value_r <= em_value;
      out_end_r   <= em_end;
      out_ovf_r   <= em_ovf;
      out_any_r   <= em_any;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_end_offset = out_end_r;
  assign out_overflow   = out_ovf_r;
  assign out_any_digits = out_any_r;

  ap_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ds_r == DS_NONE) |-> (acc_r == '0))
    else $error("accumulator nonzero before any digit");

  ap_over_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (ds_r == DS_OVER) |-> (&acc_r))
    else $error("overflow without saturated accumulator");

  ap_xseen_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_XSEEN) |-> ((base_r == TUP_BASE_HEX) && (ds_r == DS_SOME)))
    else $error("prefix phase without hex base");

  ap_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_any_r && (&out_value_r)))
    else $error("overflow result not saturated");

  ap_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_any_r) |-> ((out_value_r == '0) && (out_end_r == '0)))
    else $error("result without digits carries data");

endmodule

// ----- rtl/text_to_unsigned_parser_core.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | in_valid / in_ready        | in_ch, in_start_req
// out      | out_valid / out_ready      | out_value, out_end_offset, out_overflow,
//          |                            | out_any_digits
// cfg      | cfg_wr_en (no wait)        | cfg_wr_data (radix)
//
// one byte per cycle sustained unless out stalls; the ending byte of a result
// passes the queue, then the multiply-add and result register in the back end
// back end: a byte each cycle unless out stalls; a base-by-value multiply and add
// rst_n is synchronous; radix resets to 10, parser idles until a start byte
// out stall holds the back end; the 2-entry queue keeps taking bytes until full
module text_to_unsigned_parser_core import tup_pkg::*; #(
  parameter int VALUE_WIDTH = TUP_VALUE_WIDTH,
  parameter int MAX_CHARS   = TUP_MAX_CHARS,
  parameter int QUEUE_DEPTH = TUP_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TUP_CH_W-1:0]    in_ch,
  input  logic                   in_start_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [TUP_END_W-1:0]   out_end_offset,
  output logic                   out_overflow,
  output logic                   out_any_digits,
  input  logic                   cfg_wr_en,
  input  logic [TUP_RADIX_W-1:0] cfg_wr_data
);

  token_t push_tok, pop_tok;
  logic   q_push, q_full, q_pop, q_not_empty;

  tup_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tok        (push_tok)
  );

  tup_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_tok    (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .rd_tok    (pop_tok),
    .not_empty (q_not_empty)
  );

  tup_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (q_not_empty),
    .tok            (pop_tok),
    .tok_ready      (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_overflow   (out_overflow),
    .out_any_digits (out_any_digits)
  );

endmodule
